@@ design/ssfp_pkg.sv @@
// ----------------------------------------------------------------------------
// ssfp_pkg
// Types and constants shared by the servo status frame parser.
// ----------------------------------------------------------------------------
package ssfp_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam logic [7:0] MAX_LEN  = 8'd254;
  localparam logic [7:0] ERR_MASK = 8'h7F;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic KIND_PARAM = 1'b0;
  localparam logic KIND_END   = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HEADER   = 3'd1;
  localparam logic [2:0] ST_LENGTH   = 3'd2;
  localparam logic [2:0] ST_CHECKSUM = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  // Item after the front end has sorted it
  typedef struct packed {
    logic       is_timeout;
    logic       is_hdr;
    logic [7:0] rx_byte;
  } item_class_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [7:0] servo_id;
    logic [6:0] error_flags;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] payload_length;
  } result_t;

endpackage

@@ design/ssfp_fifo.sv @@
// ----------------------------------------------------------------------------
// ssfp_fifo
// Small register queue with a show-ahead head entry.
// ----------------------------------------------------------------------------
module ssfp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ design/ssfp_front.sv @@
// ----------------------------------------------------------------------------
// ssfp_front
// Accepts bus items, sorts them into timeout / header / other and queues
// them for the parser.
// ----------------------------------------------------------------------------
module ssfp_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ssfp_pkg::in_item_t    in_item_i,
  output logic                  full_o,
  input  logic                  take_i,
  output logic                  valid_o,
  output ssfp_pkg::item_class_t item_o
);

  ssfp_pkg::item_class_t cls;
  logic                  empty;

  always_comb begin
    cls.is_timeout = (in_item_i.op == ssfp_pkg::OP_TIMEOUT);
    cls.is_hdr     = (in_item_i.rx_byte == ssfp_pkg::HDR_BYTE);
    cls.rx_byte    = in_item_i.rx_byte;
  end

  ssfp_fifo #(
    .WIDTH ($bits(ssfp_pkg::item_class_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push_i),
    .wr_data_i (cls),
    .full_o    (full_o),
    .rd_i      (take_i),
    .rd_data_o (item_o),
    .empty_o   (empty)
  );

  assign valid_o = !empty;

endmodule

@@ design/ssfp_engine.sv @@
// ----------------------------------------------------------------------------
// ssfp_engine
// Per-byte frame parser: tracks the frame phase, the checksum and the
// parameter count, and produces parameter and frame-end results.
// ----------------------------------------------------------------------------
module ssfp_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  ssfp_pkg::item_class_t item_i,
  output logic                  take_o,
  input  logic                  res_full_i,
  output logic                  emit_o,
  output ssfp_pkg::result_t     result_o
);

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_ID,
    PH_LEN,
    PH_ERR,
    PH_PARAM,
    PH_CHK
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] frame_id_q, frame_id_d;
  logic [7:0] frame_len_q, frame_len_d;
  logic [7:0] seen_q, seen_d;
  logic [7:0] sum_q, sum_d;
  logic [6:0] err_q, err_d;
  logic       emit, hunt;
  logic [7:0] b;
  logic [8:0] seen_plus3;

  assign take_o     = valid_i && !res_full_i;
  assign emit_o     = take_o && emit;
  assign b          = item_i.rx_byte;
  assign seen_plus3 = {1'b0, seen_q} + 9'd3;

  always_comb begin
    phase_d     = phase_q;
    frame_id_d  = frame_id_q;
    frame_len_d = frame_len_q;
    seen_d      = seen_q;
    sum_d       = sum_q;
    err_d       = err_q;
    emit        = 1'b0;
    hunt        = 1'b0;

    result_o.kind           = ssfp_pkg::KIND_END;
    result_o.status         = ssfp_pkg::ST_OK;
    result_o.servo_id       = frame_id_q;
    result_o.error_flags    = err_q;
    result_o.data_byte      = '0;
    result_o.byte_index     = '0;
    result_o.payload_length = '0;

    if (item_i.is_timeout) begin
      emit                    = 1'b1;
      hunt                    = 1'b1;
      result_o.status         = ssfp_pkg::ST_TIMEOUT;
      result_o.payload_length = seen_q;
    end else begin
      case (phase_q)
        PH_HUNT1, PH_HUNT2: begin
          if (!item_i.is_hdr) begin
            emit            = 1'b1;
            hunt            = 1'b1;
            result_o.status = ssfp_pkg::ST_HEADER;
          end else begin
            phase_d = (phase_q == PH_HUNT1) ? PH_HUNT2 : PH_ID;
          end
        end
        PH_ID: begin
          frame_id_d = b;
          sum_d      = b;
          phase_d    = PH_LEN;
        end
        PH_LEN: begin
          if (b == 8'd0 || b > ssfp_pkg::MAX_LEN) begin
            emit            = 1'b1;
            hunt            = 1'b1;
            result_o.status = ssfp_pkg::ST_LENGTH;
          end else begin
            frame_len_d = b;
            sum_d       = sum_q + b;
            phase_d     = (b == 8'd1) ? PH_CHK : PH_ERR;
          end
        end
        PH_ERR: begin
          err_d   = b[6:0];
          sum_d   = sum_q + b;
          phase_d = (frame_len_q > 8'd2) ? PH_PARAM : PH_CHK;
        end
        PH_PARAM: begin
          emit                = 1'b1;
          result_o.kind       = ssfp_pkg::KIND_PARAM;
          result_o.data_byte  = b;
          result_o.byte_index = seen_q;
          sum_d               = sum_q + b;
          seen_d              = seen_q + 8'd1;
          // the last parameter leaves only the checksum byte
          if (seen_plus3 >= {1'b0, frame_len_q}) begin
            phase_d = PH_CHK;
          end
        end
        PH_CHK: begin
          emit                    = 1'b1;
          hunt                    = 1'b1;
          result_o.payload_length = seen_q;
          result_o.status = (~sum_q != b) ? ssfp_pkg::ST_CHECKSUM : ssfp_pkg::ST_OK;
        end
        default: begin
          hunt = 1'b1;
        end
      endcase
    end

    if (hunt) begin
      phase_d     = PH_HUNT1;
      frame_id_d  = '0;
      frame_len_d = '0;
      seen_d      = '0;
      sum_d       = '0;
      err_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT1;
      frame_id_q  <= '0;
      frame_len_q <= '0;
      seen_q      <= '0;
      sum_q       <= '0;
      err_q       <= '0;
    end else if (take_o) begin
      phase_q     <= phase_d;
      frame_id_q  <= frame_id_d;
      frame_len_q <= frame_len_d;
      seen_q      <= seen_d;
      sum_q       <= sum_d;
      err_q       <= err_d;
    end
  end

endmodule

@@ design/servo_status_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// servo_status_frame_parser_core
// Parser for servo status frames arriving byte by byte on a half-duplex bus.
// ----------------------------------------------------------------------------
// Accepts one bus byte or timeout event per clock while the front queue is
// not full, and gives at most one result per item. Items enter a front queue
// of FRONT_DEPTH entries; the parser state machine takes one item per cycle
// from its head while the result queue has room and writes any result into a
// result queue of RESULT_DEPTH entries, read through empty/pop. A result is
// registered into the result queue as the parser takes its item and can then
// be popped from the result ports. Sustained rate is one item per cycle; a
// full result queue stalls the parser and then the front queue.
module servo_status_frame_parser_core #(
  parameter int unsigned FRONT_DEPTH  = 2,
  parameter int unsigned RESULT_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  ssfp_pkg::in_item_t in_item_i,
  output logic               empty,
  input  logic               pop,
  output ssfp_pkg::result_t  result_o
);

  ssfp_pkg::item_class_t item;
  ssfp_pkg::result_t     eng_result;
  logic                  item_valid;
  logic                  eng_take;
  logic                  eng_emit;
  logic                  res_full;

  ssfp_front #(
    .DEPTH (FRONT_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_item_i (in_item_i),
    .full_o    (full),
    .take_i    (eng_take),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  ssfp_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (item_valid),
    .item_i     (item),
    .take_o     (eng_take),
    .res_full_i (res_full),
    .emit_o     (eng_emit),
    .result_o   (eng_result)
  );

  ssfp_fifo #(
    .WIDTH ($bits(ssfp_pkg::result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_result_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (eng_emit),
    .wr_data_i (eng_result),
    .full_o    (res_full),
    .rd_i      (pop),
    .rd_data_o (result_o),
    .empty_o   (empty)
  );

  // A result only shows up after the parser wrote one
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(eng_emit))
    else $error("result appeared without a parser write");

  // Never take an item while the result queue has no room
  a_take_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_take |-> !res_full)
    else $error("parser advanced into a full result queue");

  // Parameter results always carry ok status and no length
  a_param_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eng_emit && eng_result.kind == ssfp_pkg::KIND_PARAM) |->
      (eng_result.status == ssfp_pkg::ST_OK && eng_result.payload_length == 8'd0))
    else $error("malformed parameter result");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the servo status frame parser core.
// ----------------------------------------------------------------------------
// A short directed list covers header, length, checksum and timeout
// cases. It is followed by randomised traffic, mostly well-formed frames
// with random content and some stray bytes, broken headers and timeouts.
// Every accepted item goes through a behavioural parser in the bench.
// Each result that is popped is compared field by field with the oldest
// predicted result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ITEM_TARGET = 1950;
  localparam int HOLD_CYCLES = 120;

  typedef enum logic [2:0] {
    HUNT_HDR1, HUNT_HDR2, GET_ID, GET_LEN, GET_ERR, GET_PARAM, GET_CHK
  } frame_phase_e;

  typedef struct {
    ssfp_pkg::in_item_t item;
    bit                 typed;
    bit                 has_res;
    ssfp_pkg::result_t  res;
  } directed_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               push;
  logic               full;
  ssfp_pkg::in_item_t in_item;
  logic               empty;
  logic               pop;
  ssfp_pkg::result_t  result_o;

  // behavioural parser state
  frame_phase_e phase_q;
  logic [7:0]   id_q;
  logic [7:0]   len_q;
  logic [7:0]   seen_cnt;
  logic [7:0]   sum_q;
  logic [6:0]   err_q;

  ssfp_pkg::result_t pending_results[$];
  directed_row_t     directed_rows[$];

  int  items_sent;
  int  errors;
  int  param_count;
  int  end_count[8];
  bit  quiet;
  bit  no_sender_gaps;
  bit  hold_request;
  bit  hold_done;
  bit  drain_done;
  int  waited;

  servo_status_frame_parser_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .in_item_i(in_item),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("** servo_status_frame_parser_core: FAILED **");
    $finish;
  end

  function automatic void hunt_reset();
    phase_q  = HUNT_HDR1;
    id_q     = '0;
    len_q    = '0;
    seen_cnt = '0;
    sum_q    = '0;
    err_q    = '0;
  endfunction

  function automatic ssfp_pkg::result_t close_frame(input logic [2:0] st,
                                                    input logic [7:0] plen);
    ssfp_pkg::result_t r;
    r                = '0;
    r.kind           = ssfp_pkg::KIND_END;
    r.status         = st;
    r.servo_id       = id_q;
    r.error_flags    = err_q;
    r.payload_length = plen;
    hunt_reset();
    return r;
  endfunction

  // Advance the parser by one item; returns 1 when a result is due.
  function automatic bit frame_parse_step(input ssfp_pkg::in_item_t item,
                                          output ssfp_pkg::result_t res);
    logic [7:0] b;
    bit         emit;
    b    = item.rx_byte;
    res  = '0;
    emit = 1'b0;
    if (item.op == ssfp_pkg::OP_TIMEOUT) begin
      res  = close_frame(ssfp_pkg::ST_TIMEOUT, seen_cnt);
      emit = 1'b1;
    end else begin
      case (phase_q)
        HUNT_HDR1, HUNT_HDR2: begin
          if (b != ssfp_pkg::HDR_BYTE) begin
            res  = close_frame(ssfp_pkg::ST_HEADER, 8'd0);
            emit = 1'b1;
          end else if (phase_q == HUNT_HDR1) begin
            phase_q = HUNT_HDR2;
          end else begin
            phase_q = GET_ID;
          end
        end
        GET_ID: begin
          id_q    = b;
          sum_q   = b;
          phase_q = GET_LEN;
        end
        GET_LEN: begin
          if (b == 8'd0 || b > ssfp_pkg::MAX_LEN) begin
            res  = close_frame(ssfp_pkg::ST_LENGTH, 8'd0);
            emit = 1'b1;
          end else begin
            len_q = b;
            sum_q = sum_q + b;
            if (b == 8'd1) phase_q = GET_CHK;
            else phase_q = GET_ERR;
          end
        end
        GET_ERR: begin
          err_q = b[6:0];
          sum_q = sum_q + b;
          if (len_q > 8'd2) phase_q = GET_PARAM;
          else phase_q = GET_CHK;
        end
        GET_PARAM: begin
          res.kind        = ssfp_pkg::KIND_PARAM;
          res.status      = ssfp_pkg::ST_OK;
          res.servo_id    = id_q;
          res.error_flags = err_q;
          res.data_byte   = b;
          res.byte_index  = seen_cnt;
          emit            = 1'b1;
          sum_q           = sum_q + b;
          seen_cnt        = seen_cnt + 8'd1;
          if (int'(seen_cnt) + 2 >= int'(len_q)) phase_q = GET_CHK;
        end
        GET_CHK: begin
          if ((~sum_q) == b) res = close_frame(ssfp_pkg::ST_OK, seen_cnt);
          else res = close_frame(ssfp_pkg::ST_CHECKSUM, seen_cnt);
          emit = 1'b1;
        end
        default: hunt_reset();
      endcase
    end
    return emit;
  endfunction

  function automatic ssfp_pkg::result_t end_res(input logic [2:0] st, input logic [7:0] id,
                                                input logic [6:0] flags,
                                                input logic [7:0] plen);
    ssfp_pkg::result_t r;
    r                = '0;
    r.kind           = ssfp_pkg::KIND_END;
    r.status         = st;
    r.servo_id       = id;
    r.error_flags    = flags;
    r.payload_length = plen;
    return r;
  endfunction

  task automatic add_row(input logic op, input logic [7:0] b, input bit typed,
                         input bit has_res, input ssfp_pkg::result_t res);
    directed_row_t row;
    row.item.op      = op;
    row.item.rx_byte = b;
    row.typed        = typed;
    row.has_res      = has_res;
    row.res          = res;
    directed_rows.push_back(row);
  endtask

  task automatic sender_idle(input int n);
    repeat (n) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
  endtask

  // Offer one item and hold it until the transfer; typed rows carry their
  // own expectation, all others take the parser's.
  task automatic offer(input ssfp_pkg::in_item_t item, input bit typed, input bit has_res,
                       input ssfp_pkg::result_t res);
    ssfp_pkg::result_t predicted;
    bit                due;
    if (!quiet && !no_sender_gaps && $urandom_range(0, 9) == 0)
      sender_idle($urandom_range(1, 14));
    @(negedge clk_i);
    push    <= 1'b1;
    in_item <= item;
    do @(posedge clk_i); while (full);
    due = frame_parse_step(item, predicted);
    if (typed) begin
      if (has_res) pending_results.push_back(res);
    end else if (due) begin
      pending_results.push_back(predicted);
    end
    items_sent++;
  endtask

  task automatic send_random_frame();
    logic [7:0]         frame_bytes[$];
    logic [7:0]         b;
    logic [7:0]         id;
    logic [7:0]         len;
    logic [7:0]         sum;
    ssfp_pkg::in_item_t item;
    int                 pick;
    int                 sel;
    int                 nsend;
    int                 i;
    bit                 abort;
    pick  = $urandom_range(0, 99);
    abort = 1'b0;
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(0, 254));
        frame_bytes.push_back(b);
      end
    end else if (pick < 12) begin
      abort = 1'b1;
    end else if (pick < 16) begin
      b = 8'($urandom_range(0, 254));
      frame_bytes.push_back(ssfp_pkg::HDR_BYTE);
      frame_bytes.push_back(b);
    end else if (pick < 20) begin
      id = 8'($urandom_range(0, 255));
      b  = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
      frame_bytes.push_back(ssfp_pkg::HDR_BYTE);
      frame_bytes.push_back(ssfp_pkg::HDR_BYTE);
      frame_bytes.push_back(id);
      frame_bytes.push_back(b);
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 10) len = 8'd1;
      else if (sel < 20) len = 8'd2;
      else if (sel < 21)
        len = $urandom_range(0, 1) ? ssfp_pkg::MAX_LEN : 8'($urandom_range(200, 253));
      else len = 8'($urandom_range(3, 12));
      id  = 8'($urandom_range(0, 255));
      sum = id + len;
      frame_bytes.push_back(ssfp_pkg::HDR_BYTE);
      frame_bytes.push_back(ssfp_pkg::HDR_BYTE);
      frame_bytes.push_back(id);
      frame_bytes.push_back(len);
      if (len >= 8'd2) begin
        b   = 8'($urandom_range(0, 255));
        sum = sum + b;
        frame_bytes.push_back(b);
      end
      for (i = 0; i < int'(len) - 2; i++) begin
        b   = 8'($urandom_range(0, 255));
        sum = sum + b;
        frame_bytes.push_back(b);
      end
      b = ~sum;
      if ($urandom_range(0, 6) == 0) b = b ^ 8'($urandom_range(1, 255));
      frame_bytes.push_back(b);
      abort = ($urandom_range(0, 11) == 0);
    end
    nsend = frame_bytes.size();
    if (abort && nsend > 0) nsend = $urandom_range(0, nsend - 1);
    for (i = 0; i < nsend; i++) begin
      item.op      = ssfp_pkg::OP_BYTE;
      item.rx_byte = frame_bytes[i];
      offer(item, 1'b0, 1'b0, '0);
    end
    if (abort) begin
      item.op      = ssfp_pkg::OP_TIMEOUT;
      item.rx_byte = 8'($urandom_range(0, 255));
      offer(item, 1'b0, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    pop   = 1'b0;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall        = HOLD_CYCLES;
      end else if (stall == 0 && !quiet && $urandom_range(0, 11) == 0) begin
        stall = $urandom_range(1, 14);
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Check each result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    ssfp_pkg::result_t exp_res;
    if (rst_ni && pop && !empty) begin
      if (result_o.kind == ssfp_pkg::KIND_PARAM) param_count++;
      else end_count[result_o.status]++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind=%0d status=%0d id=%02h", result_o.kind,
                   result_o.status, result_o.servo_id);
      end else begin
        exp_res = pending_results.pop_front();
        if (result_o.kind !== exp_res.kind || result_o.status !== exp_res.status ||
            result_o.servo_id !== exp_res.servo_id ||
            result_o.error_flags !== exp_res.error_flags ||
            result_o.data_byte !== exp_res.data_byte ||
            result_o.byte_index !== exp_res.byte_index ||
            result_o.payload_length !== exp_res.payload_length) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp k=%0d st=%0d id=%02h fl=%02h d=%02h ix=%0d pl=%0d",
                      " | got k=%0d st=%0d id=%02h fl=%02h d=%02h ix=%0d pl=%0d"},
                     exp_res.kind, exp_res.status, exp_res.servo_id, exp_res.error_flags,
                     exp_res.data_byte, exp_res.byte_index, exp_res.payload_length,
                     result_o.kind, result_o.status, result_o.servo_id,
                     result_o.error_flags, result_o.data_byte, result_o.byte_index,
                     result_o.payload_length);
        end
      end
    end
  end

  initial begin
    rst_ni  = 1'b0;
    push    = 1'b0;
    in_item = '0;
    hunt_reset();

    // stray byte and timeout while hunting
    add_row(ssfp_pkg::OP_BYTE,    8'h00, 1, 1,
            end_res(ssfp_pkg::ST_HEADER, 8'h00, 7'h00, 8'd0));
    add_row(ssfp_pkg::OP_TIMEOUT, 8'h5A, 1, 1,
            end_res(ssfp_pkg::ST_TIMEOUT, 8'h00, 7'h00, 8'd0));
    // length zero
    add_row(ssfp_pkg::OP_BYTE,    ssfp_pkg::HDR_BYTE, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    ssfp_pkg::HDR_BYTE, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    8'hFE, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    8'h00, 1, 1,
            end_res(ssfp_pkg::ST_LENGTH, 8'hFE, 7'h00, 8'd0));
    // length 255
    add_row(ssfp_pkg::OP_BYTE,    ssfp_pkg::HDR_BYTE, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    ssfp_pkg::HDR_BYTE, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    8'h01, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    8'hFF, 1, 1,
            end_res(ssfp_pkg::ST_LENGTH, 8'h01, 7'h00, 8'd0));
    // length one: checksum only
    add_row(ssfp_pkg::OP_BYTE,    ssfp_pkg::HDR_BYTE, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    ssfp_pkg::HDR_BYTE, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    8'h05, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    8'h01, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    8'hF9, 1, 1,
            end_res(ssfp_pkg::ST_OK, 8'h05, 7'h00, 8'd0));
    // length two, error byte all ones, wrong checksum
    add_row(ssfp_pkg::OP_BYTE,    ssfp_pkg::HDR_BYTE, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    ssfp_pkg::HDR_BYTE, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    8'h00, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    8'h02, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    8'hFF, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    8'h00, 1, 1,
            end_res(ssfp_pkg::ST_CHECKSUM, 8'h00, 7'h7F, 8'd0));
    // one parameter, then a timeout mid-frame
    add_row(ssfp_pkg::OP_BYTE,    ssfp_pkg::HDR_BYTE, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    ssfp_pkg::HDR_BYTE, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    8'hFF, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    8'h03, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    8'h80, 1, 0, '0);
    add_row(ssfp_pkg::OP_BYTE,    8'hFF, 0, 0, '0);
    add_row(ssfp_pkg::OP_TIMEOUT, 8'h00, 0, 0, '0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].has_res,
            directed_rows[i].res);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= 700 && !hold_done) begin
        hold_done      = 1'b1;
        hold_request   = 1'b1;
        no_sender_gaps = 1'b1;
      end
      if (items_sent >= 850) no_sender_gaps = 1'b0;
      if (items_sent >= 1200 && !drain_done) begin
        // hold the input until every pending result has been read out
        drain_done = 1'b1;
        sender_idle(1);
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      if (items_sent >= 1750) quiet = 1'b1;
      send_random_frame();
    end

    sender_idle(1);
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0d predicted results never arrived", pending_results.size());
    end

    $display("Parsed %0d items: %0d parameter bytes, frame ends ok/header/length/cksum/timeout",
             items_sent, param_count);
    $display("  = %0d/%0d/%0d/%0d/%0d, %0d errors", end_count[ssfp_pkg::ST_OK],
             end_count[ssfp_pkg::ST_HEADER], end_count[ssfp_pkg::ST_LENGTH],
             end_count[ssfp_pkg::ST_CHECKSUM], end_count[ssfp_pkg::ST_TIMEOUT], errors);
    if (errors == 0) begin
      $display("** servo_status_frame_parser_core: PASSED **");
    end else begin
      $display("** servo_status_frame_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
